// ===== sv/pcxrle_pkg.sv =====
// shared types and constants for the pcx rle palette decoder
// no dependencies
package pcxrle_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = 8;
  localparam int RGB_W           = 24;
  localparam int REG_W           = 9;
  localparam int RUN_W           = 6;

  localparam logic [7:0] RUN_MARK     = 8'hC0;
  localparam logic [7:0] RUN_LEN_MASK = 8'h3F;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 9'd320;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 9'd200;

  typedef enum logic [1:0] {
    CMD_PALETTE   = 2'd0,
    CMD_DATA      = 2'd1,
    CMD_NEW_IMAGE = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic eor;
    logic eoi;
    logic done;
  } raster_status_t;

endpackage

// ===== sv/pcxrle_palette_ram.sv =====
// 256 x 24 palette memory, one write and one registered read port
// depends on pcxrle_pkg
module pcxrle_palette_ram
  import pcxrle_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [PAL_AW-1:0] waddr,
  input  logic [RGB_W-1:0]  wdata,
  input  logic              re,
  input  logic [PAL_AW-1:0] raddr,
  output logic [RGB_W-1:0]  rdata
);

  logic [RGB_W-1:0] mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pcxrle_raster.sv =====
// column and row position of the decoded image, row and image end flags
// depends on pcxrle_pkg
module pcxrle_raster
  import pcxrle_pkg::*;
#(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [REG_W-1:0] image_width,
  input  logic [REG_W-1:0] image_height,
  input  logic             clear,
  input  logic             advance,
  output raster_status_t   status
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW = ($clog2(MAX_WIDTH + 1) > REG_W) ? $clog2(MAX_WIDTH + 1) : REG_W;
  localparam int HCW = ($clog2(MAX_HEIGHT + 1) > REG_W) ? $clog2(MAX_HEIGHT + 1) : REG_W;
  localparam logic [WCW-1:0] W_MAX = WCW'(MAX_WIDTH);
  localparam logic [HCW-1:0] H_MAX = HCW'(MAX_HEIGHT);

  logic [CW-1:0]  column;
  logic [RW-1:0]  row;
  logic           done;
  logic [WCW-1:0] width_ext;
  logic [HCW-1:0] height_ext;
  logic [WCW-1:0] width_last;
  logic [HCW-1:0] height_last;
  logic           eor;
  logic           eoi;

  // saturate registers to 1..max, then take the last position
  always_comb begin
    width_ext  = WCW'(image_width);
    height_ext = HCW'(image_height);
    if (width_ext == '0) begin
      width_last = '0;
    end else if (width_ext > W_MAX) begin
      width_last = W_MAX - WCW'(1);
    end else begin
      width_last = width_ext - WCW'(1);
    end
    if (height_ext == '0) begin
      height_last = '0;
    end else if (height_ext > H_MAX) begin
      height_last = H_MAX - HCW'(1);
    end else begin
      height_last = height_ext - HCW'(1);
    end
  end

  assign eor = WCW'(column) >= width_last;
  assign eoi = eor && (HCW'(row) >= height_last);

  assign status = '{eor: eor, eoi: eoi, done: done};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      column <= '0;
      row    <= '0;
      done   <= 1'b0;
    end else if (advance) begin
      if (eor) begin
        column <= '0;
        if (eoi) begin
          done <= 1'b1;
        end else begin
          row <= row + RW'(1);
        end
      end else begin
        column <= column + CW'(1);
      end
    end
  end

  property p_no_advance_when_done;
    @(posedge clk) disable iff (rst) advance |-> !done;
  endproperty
  a_no_advance_when_done: assert property (p_no_advance_when_done)
    else $error("raster advanced after image end");

  property p_done_from_eoi;
    @(posedge clk) disable iff (rst) $rose(done) |-> $past(advance && eoi);
  endproperty
  a_done_from_eoi: assert property (p_done_from_eoi)
    else $error("image end set without last pixel");

  property p_column_wraps;
    @(posedge clk) disable iff (rst) (advance && eor && !clear) |=> column == '0;
  endproperty
  a_column_wraps: assert property (p_column_wraps)
    else $error("column did not wrap at row end");

endmodule

// ===== sv/pcxrle_palette_decoder_unit.sv =====
// pcx rle palette decoder top level: request decode, run sequencer and output
// depends on pcxrle_pkg, pcxrle_palette_ram, pcxrle_raster
// latency: first pixel of a literal or run appears the cycle after its request
// a literal emits one pixel and a run emits its count, cut short at a row end;
// pixels leave one per cycle while m_tready is high, after the registered palette read
// input is held while a literal or run drains; other requests are taken in idle
// reset: control state cleared, width 320, height 200; palette keeps contents
module pcx_rle_palette_decoder_unit
  import pcxrle_pkg::*;
#(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [39:0]      s_tdata,  // data_byte, palette_index, palette_rgb
  input  logic [1:0]       s_tuser,  // cmd
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,  // red, green, blue
  output logic [1:0]       m_tuser,  // end_of_row, end_of_image
  output logic             m_tlast,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  state_t             state;
  state_t             state_next;
  logic [REG_W-1:0]   image_width;
  logic [REG_W-1:0]   image_height;
  logic               awaiting;
  logic [RUN_W-1:0]   pending_run;
  logic [RUN_W-1:0]   remaining;
  logic [RGB_W-1:0]   rgb;
  raster_status_t     status;
  cmd_t               cmd;
  logic [7:0]         data_byte;
  logic               in_fire;
  logic               out_fire;
  logic               is_data;
  logic               is_mark;
  logic               start_run;
  logic               start_lit;
  logic               new_image;

  assign cmd       = cmd_t'(s_tuser);
  assign data_byte = s_tdata[7:0];
  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;
  assign is_mark   = (data_byte & RUN_MARK) == RUN_MARK;
  assign is_data   = in_fire && (cmd == CMD_DATA) && !status.done;
  assign new_image = in_fire && (cmd == CMD_NEW_IMAGE);
  assign start_run = is_data && awaiting && (pending_run != '0);
  assign start_lit = is_data && !awaiting && !is_mark;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  pcxrle_palette_ram u_palette (
    .clk   (clk),
    .we    (in_fire && (cmd == CMD_PALETTE)),
    .waddr (s_tdata[15:8]),
    .wdata (s_tdata[39:16]),
    .re    (start_run || start_lit),
    .raddr (data_byte),
    .rdata (rgb)
  );

  pcxrle_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .clear        (new_image),
    .advance      (out_fire),
    .status       (status)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_run || start_lit) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire && m_tlast) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EMIT: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_tdata = {rgb[7:0], rgb[15:8], rgb[23:16]};
  assign m_tuser = {status.eoi, status.eor};
  assign m_tlast = (remaining == RUN_W'(1)) || status.eor;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      awaiting    <= 1'b0;
      pending_run <= '0;
      remaining   <= '0;
    end else begin
      state <= state_next;
      if (new_image) begin
        awaiting    <= 1'b0;
        pending_run <= '0;
      end else if (is_data) begin
        if (awaiting) begin
          awaiting    <= 1'b0;
          pending_run <= '0;
        end else if (is_mark) begin
          awaiting    <= 1'b1;
          pending_run <= RUN_W'(data_byte & RUN_LEN_MASK);
        end
      end
      if (start_run) begin
        remaining <= pending_run;
      end else if (start_lit) begin
        remaining <= RUN_W'(1);
      end else if (out_fire) begin
        remaining <= remaining - RUN_W'(1);
      end
    end
  end

  property p_interlock;
    @(posedge clk) disable iff (rst) m_tvalid |-> !s_tready;
  endproperty
  a_interlock: assert property (p_interlock)
    else $error("request taken while pixels pending");

  property p_last_ends_burst;
    @(posedge clk) disable iff (rst) (out_fire && m_tlast) |=> !m_tvalid;
  endproperty
  a_last_ends_burst: assert property (p_last_ends_burst)
    else $error("pixel after last of request");

  property p_image_end_is_last;
    @(posedge clk) disable iff (rst) (m_tvalid && m_tuser[1]) |-> m_tlast;
  endproperty
  a_image_end_is_last: assert property (p_image_end_is_last)
    else $error("image end pixel not marked last");

  property p_remaining_live;
    @(posedge clk) disable iff (rst) (state == ST_EMIT) |-> (remaining != '0);
  endproperty
  a_remaining_live: assert property (p_remaining_live)
    else $error("emitting with empty run count");

endmodule
